FILE: rtl/chse_pkg.sv
// Shared widths, types and helper functions of the cubic Hermite segment evaluator.
`timescale 1ns / 1ps
`default_nettype none

package chse_pkg;

	localparam int unsigned U_FRAC_BITS = 24;

	// u and its powers: unsigned, one integer bit so that 1.0 fits
	localparam int unsigned QW  = U_FRAC_BITS + 1;
	// basis weights: signed, room for +-8.0
	localparam int unsigned WW  = U_FRAC_BITS + 4;
	// weight times a 33-bit operand, and the sum of two such
	localparam int unsigned PRW = WW + 33;
	localparam int unsigned PW  = PRW + 1;
	// term magnitude, holds the cap 2^40
	localparam int unsigned TW  = 41;

	localparam int unsigned DIV_QW  = TW;
	localparam int unsigned DIV_NW  = PW + 32;
	localparam int unsigned DIV_DW  = U_FRAC_BITS + 32;
	localparam int unsigned DIV_RW  = DIV_NW - DIV_QW;
	localparam int unsigned DIV_LAT = DIV_QW + 1;

	localparam int unsigned BASIS_LAT = 3;
	localparam int unsigned MS_PER_S  = 1000;

	// 1000 = 125 * 2^3: divide by 1000 * 2^F as a shift, then a reciprocal multiply by 1/125
	localparam int unsigned MS_ODD  = 125;
	localparam int unsigned MS_SH   = U_FRAC_BITS + 3;
	localparam int unsigned MS_MW   = DIV_NW - MS_SH;
	localparam int unsigned RCP_SH  = 54;
	localparam int unsigned RCP_W   = 48;
	localparam int unsigned LIMB    = RCP_W / 2;
	// two product stages run ahead of the delay line that matches the divider latency
	localparam int unsigned POS_DLY = DIV_LAT - 2;

	localparam logic [TW-1:0]     TERM_CAP = TW'(1) << (TW - 1);
	localparam logic [QW-1:0]     U_ONE    = QW'(1) << U_FRAC_BITS;
	localparam logic [RCP_W-1:0]  RCP_ODD  = RCP_W'((64'd1 << RCP_SH) / MS_ODD + 64'd1);
	localparam logic [MS_MW-1:0]  MS_LIM   = MS_MW'(MS_ODD) << (TW - 1);

	typedef logic signed [WW-1:0] wt_t;

	typedef struct packed {
		wt_t h00;
		wt_t h01;
		wt_t h10;
		wt_t h11;
		wt_t dh00;
		wt_t dh10;
		wt_t dh11;
	} basis_t;

	// magnitude of a signed sum
	function automatic logic [PW-1:0] mag_of(input logic signed [PW-1:0] v);
		return v[PW-1] ? PW'(-v) : PW'(v);
	endfunction

	// drop the fraction and cap the magnitude
	function automatic logic [TW-1:0] cap_term(input logic [PW-1:0] mag);
		logic [PW-U_FRAC_BITS-1:0] sh;
		sh = mag[PW-1:U_FRAC_BITS];
		return (sh >= TERM_CAP) ? TERM_CAP : TW'(sh);
	endfunction

	function automatic logic signed [TW:0] apply_sign(input logic neg, input logic [TW-1:0] t);
		logic signed [TW:0] s;
		s = $signed({1'b0, t});
		return neg ? -s : s;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [TW+1:0] v);
		logic signed [31:0] r;
		if (v[TW+1:31] == '0 || v[TW+1:31] == '1) begin
			r = v[31:0];
		end else begin
			r = v[TW+1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/chse_div.sv
// Pipelined restoring divider, one quotient bit per stage, quotient capped at TERM_CAP.
`timescale 1ns / 1ps
`default_nettype none

module chse_div import chse_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [DIV_NW-1:0] num,
	input  logic [DIV_DW-1:0] den,
	output logic              out_vld,
	output logic [DIV_QW-1:0] quo
);

	logic [DIV_DW-1:0] rem_s [DIV_QW+1];
	logic [DIV_QW-1:0] lo_s  [DIV_QW+1];
	logic [DIV_QW-1:0] quo_s [DIV_QW+1];
	logic [DIV_DW-1:0] den_s [DIV_QW+1];
	logic              ovf_s [DIV_QW+1];
	logic              vld_s [DIV_QW+1];

	logic [DIV_DW-1:0] head;

	// high part of the numerator; not below the divisor means overflow
	assign head = {{(DIV_DW - DIV_RW){1'b0}}, num[DIV_NW-1:DIV_QW]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= head;
			lo_s[0]  <= num[DIV_QW-1:0];
			quo_s[0] <= '0;
			den_s[0] <= den;
			ovf_s[0] <= (head >= den);
		end
	end

	for (genvar k = 1; k <= DIV_QW; k++) begin : g_stage
		logic [DIV_DW:0] trial;
		logic            take;

		assign trial = {rem_s[k-1], lo_s[k-1][DIV_QW-k]};
		assign take  = (trial >= {1'b0, den_s[k-1]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= take ? DIV_DW'(trial - {1'b0, den_s[k-1]}) : DIV_DW'(trial);
				lo_s[k]  <= lo_s[k-1];
				quo_s[k] <= {quo_s[k-1][DIV_QW-2:0], take};
				den_s[k] <= den_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
			end
		end
	end

	assign out_vld = vld_s[DIV_QW];
	assign quo     = (ovf_s[DIV_QW] || quo_s[DIV_QW] > TERM_CAP) ? TERM_CAP : quo_s[DIV_QW];

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[DIV_QW] && !ovf_s[DIV_QW] |-> rem_s[DIV_QW] < den_s[DIV_QW])
		else $error("divider remainder not below divisor");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s[DIV_QW]) && (!vld_s[DIV_QW] || $stable(quo_s[DIV_QW])))
		else $error("divider moved while stalled");

	a_no_entry_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s[0]))
		else $error("divider entry changed while stalled");

endmodule

`default_nettype wire

FILE: rtl/chse_basis.sv
// Three-stage Hermite basis: u^2, u^3, then the seven weights and slopes.
`timescale 1ns / 1ps
`default_nettype none

module chse_basis import chse_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_vld,
	input  logic [QW-1:0] q,
	output logic          out_vld,
	output basis_t        wts
);

	logic          vld_s1, vld_s2, vld_s3;
	logic [QW-1:0] q_s1, q2_s1, q_s2, q2_s2, q3_s2;
	basis_t        wts_s3;

	logic [2*QW-1:0] qq, qqq;
	wt_t             qw, q2w, q3w, onew, t;
	basis_t          wts_c;

	assign qq  = (2*QW)'(q) * (2*QW)'(q);
	assign qqq = (2*QW)'(q2_s1) * (2*QW)'(q_s1);

	assign qw   = $signed({{(WW - QW){1'b0}}, q_s2});
	assign q2w  = $signed({{(WW - QW){1'b0}}, q2_s2});
	assign q3w  = $signed({{(WW - QW){1'b0}}, q3_s2});
	assign onew = $signed({{(WW - QW){1'b0}}, U_ONE});
	assign t    = q2w - qw;

	always_comb begin
		wts_c.h00  = q3w + q3w - q2w - q2w - q2w + onew;
		wts_c.h10  = q3w - q2w - q2w + qw;
		wts_c.h01  = q2w + q2w + q2w - q3w - q3w;
		wts_c.h11  = q3w - q2w;
		wts_c.dh00 = (t <<< 2) + (t <<< 1);
		wts_c.dh10 = q2w + q2w + q2w - (qw <<< 2) + onew;
		wts_c.dh11 = q2w + q2w + q2w - qw - qw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s1   <= q;
			q2_s1  <= qq[QW+U_FRAC_BITS-1:U_FRAC_BITS];
			q_s2   <= q_s1;
			q2_s2  <= q2_s1;
			q3_s2  <= qqq[QW+U_FRAC_BITS-1:U_FRAC_BITS];
			wts_s3 <= wts_c;
		end
	end

	assign out_vld = vld_s3;
	assign wts     = wts_s3;

endmodule

`default_nettype wire

FILE: rtl/cubic_hermite_segment_eval.sv
// Throughput: one transaction per cycle while the output is not stalled; the pipeline is fully pipelined end to end.
// The pipeline depth is set by the u divider and the velocity tangent divider in series
// (42 stages each) plus nine other stages.
// Backpressure: the whole pipeline holds while the output register is full and stalled.
// Reset: arst_n clears all valid bits at once; payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module cubic_hermite_segment_eval import chse_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] start_position,
	input  logic signed [31:0] start_velocity,
	input  logic        [31:0] start_time_ms,
	input  logic signed [31:0] end_position,
	input  logic signed [31:0] end_velocity,
	input  logic        [31:0] end_time_ms,
	input  logic        [31:0] elapsed_ms,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] position_out,
	output logic signed [31:0] velocity_out
);

	// Waypoint data riding alongside the u divider and the basis stages.
	typedef struct packed {
		logic signed [31:0] p0;
		logic signed [31:0] v0;
		logic signed [31:0] p1;
		logic signed [31:0] v1;
		logic        [31:0] d;
		logic               dz;
		logic               ge;
		logic               vok;
	} side_t;

	// Finished terms and flags riding alongside the velocity tangent divider.
	typedef struct packed {
		logic               na;
		logic [TW-1:0]      ta;
		logic               nb;
		logic               nc;
		logic               ne;
		logic [TW-1:0]      te;
		logic signed [31:0] p0;
		logic        [31:0] d;
		logic               dz;
		logic               vok;
	} term_t;

	logic en;

	// Advance everything unless a finished result is waiting and stalled.
	assign en       = !out_valid || !out_stall;
	assign in_stall = !en;

	// ---------------------------------------------------------------- stage 1: capture
	logic               vld_s1;
	logic signed [31:0] p0_s1, v0_s1, p1_s1, v1_s1;
	logic        [31:0] d_s1, el_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p0_s1 <= start_position;
			v0_s1 <= start_velocity;
			p1_s1 <= end_position;
			v1_s1 <= end_velocity;
			d_s1  <= end_time_ms - start_time_ms;   // modular duration
			el_s1 <= elapsed_ms;
		end
	end

	// ---------------------------------------------------------------- u = elapsed / duration
	side_t              side_in;
	side_t              side1_q [DIV_LAT];
	side_t              side1_o;
	logic               ge_s1;
	logic [DIV_NW-1:0]  uq_num;
	logic               uq_vld;
	logic [DIV_QW-1:0]  uq_quo;

	assign ge_s1 = (el_s1 >= d_s1);

	always_comb begin
		side_in.p0  = p0_s1;
		side_in.v0  = v0_s1;
		side_in.p1  = p1_s1;
		side_in.v1  = v1_s1;
		side_in.d   = d_s1;
		side_in.dz  = (d_s1 == '0);
		side_in.ge  = ge_s1;
		side_in.vok = (el_s1 != '0) && !ge_s1;
	end

	// Past the end the quotient is replaced by 1.0; feed zero to keep it quiet.
	assign uq_num = ge_s1 ? '0 : DIV_NW'({el_s1, {U_FRAC_BITS{1'b0}}});

	chse_div u_div_u (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s1),
		.num     (uq_num),
		.den     (DIV_DW'(d_s1)),
		.out_vld (uq_vld),
		.quo     (uq_quo)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			side1_q[0] <= side_in;
			for (int i = 1; i < DIV_LAT; i++) begin
				side1_q[i] <= side1_q[i-1];
			end
		end
	end

	assign side1_o = side1_q[DIV_LAT-1];

	// ---------------------------------------------------------------- basis weights
	logic [QW-1:0] u_q;
	logic          bas_vld;
	basis_t        wts;
	side_t         side2_q [BASIS_LAT];
	side_t         side2_o;

	// Clamp u to 1.0 at or past the end of the segment.
	assign u_q = side1_o.ge ? U_ONE : {1'b0, uq_quo[U_FRAC_BITS-1:0]};

	chse_basis u_basis (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (uq_vld),
		.q       (u_q),
		.out_vld (bas_vld),
		.wts     (wts)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			side2_q[0] <= side1_o;
			for (int i = 1; i < BASIS_LAT; i++) begin
				side2_q[i] <= side2_q[i-1];
			end
		end
	end

	assign side2_o = side2_q[BASIS_LAT-1];

	// ---------------------------------------------------------------- stage 3: products
	logic                  vld_s3;
	logic signed [PRW-1:0] pa0_s3, pa1_s3, pb0_s3, pb1_s3, pc_s3, pe0_s3, pe1_s3;
	logic signed [31:0]    p0_s3;
	logic        [31:0]    d_s3;
	logic                  dz_s3, vok_s3;
	logic signed [32:0]    dp;

	assign dp = $signed({side2_o.p0[31], side2_o.p0}) - $signed({side2_o.p1[31], side2_o.p1});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= bas_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pa0_s3 <= $signed(wts.h00)  * $signed(side2_o.p0);
			pa1_s3 <= $signed(wts.h01)  * $signed(side2_o.p1);
			pb0_s3 <= $signed(wts.h10)  * $signed(side2_o.v0);
			pb1_s3 <= $signed(wts.h11)  * $signed(side2_o.v1);
			pc_s3  <= $signed(wts.dh00) * dp;
			pe0_s3 <= $signed(wts.dh10) * $signed(side2_o.v0);
			pe1_s3 <= $signed(wts.dh11) * $signed(side2_o.v1);
			p0_s3  <= side2_o.p0;
			d_s3   <= side2_o.d;
			dz_s3  <= side2_o.dz;
			vok_s3 <= side2_o.vok;
		end
	end

	// ---------------------------------------------------------------- stage 4: sums, sign and magnitude
	logic signed [PW-1:0] sum_a, sum_b, sum_c, sum_e;
	logic                 vld_s4;
	term_t                ts_s4;
	logic [PW-1:0]        magb_s4, magc_s4;

	assign sum_a = PW'(pa0_s3) + PW'(pa1_s3);
	assign sum_b = PW'(pb0_s3) + PW'(pb1_s3);
	assign sum_c = PW'(pc_s3);
	assign sum_e = PW'(pe0_s3) + PW'(pe1_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ts_s4.na  <= sum_a[PW-1];
			ts_s4.ta  <= cap_term(mag_of(sum_a));
			ts_s4.nb  <= sum_b[PW-1];
			ts_s4.nc  <= sum_c[PW-1];
			ts_s4.ne  <= sum_e[PW-1];
			ts_s4.te  <= cap_term(mag_of(sum_e));
			ts_s4.p0  <= p0_s3;
			ts_s4.d   <= d_s3;
			ts_s4.dz  <= dz_s3;
			ts_s4.vok <= vok_s3;
			magb_s4   <= mag_of(sum_b);
			magc_s4   <= mag_of(sum_c);
		end
	end

	// ---------------------------------------------------------------- stage 5: tangent times duration, split
	logic          vld_s5;
	term_t         ts_s5;
	logic [63:0]   blo_s5;
	logic [PW-1:0] bhi_s5;
	logic [PW-1:0] magc_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			blo_s5  <= 64'(magb_s4[31:0]) * 64'(ts_s4.d);
			bhi_s5  <= PW'(magb_s4[PW-1:32]) * PW'(ts_s4.d);
			magc_s5 <= magc_s4;
			ts_s5   <= ts_s4;
		end
	end

	// ---------------------------------------------------------------- stage 6: numerators
	logic              vld_s6;
	term_t             ts_s6;
	logic [DIV_NW-1:0] numb_s6, numc_s6;
	logic [DIV_DW-1:0] denc_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			numb_s6 <= DIV_NW'(blo_s5) + {bhi_s5, 32'b0};
			numc_s6 <= DIV_NW'(magc_s5) * DIV_NW'(MS_PER_S);
			denc_s6 <= {ts_s5.d, {U_FRAC_BITS{1'b0}}};
			ts_s6   <= ts_s5;
		end
	end

	// ---------------------------------------------------------------- position tangent: / (1000 * 2^F)
	// Shift out 2^(F+3), cap at 125 * 2^40, then multiply by 2^54/125 rounded up.
	// Below the cap the shifted value has at most 47 bits, so the floor is exact.
	logic [MS_MW-1:0]   mb;
	logic [LIMB-1:0]    mlo_s7, mhi_s7;
	logic               capb_s7, capb_s8;
	logic [RCP_W-1:0]   pll_s8, plh_s8, phl_s8, phh_s8;
	logic [2*RCP_W-1:0] psum;
	logic [TW-1:0]      tb_c;
	logic [TW-1:0]      tb_q [POS_DLY];

	assign mb = numb_s6[DIV_NW-1:MS_SH];

	assign psum = ((2*RCP_W)'(phh_s8) << (2*LIMB))
		+ (((2*RCP_W)'(plh_s8) + (2*RCP_W)'(phl_s8)) << LIMB)
		+ (2*RCP_W)'(pll_s8);

	assign tb_c = capb_s8 ? TERM_CAP : {1'b0, psum[RCP_SH+TW-2:RCP_SH]};

	always_ff @(posedge clk) begin
		if (en) begin
			mlo_s7  <= mb[LIMB-1:0];
			mhi_s7  <= mb[2*LIMB-1:LIMB];
			capb_s7 <= (mb >= MS_LIM);
			pll_s8  <= RCP_W'(mlo_s7) * RCP_W'(RCP_ODD[LIMB-1:0]);
			plh_s8  <= RCP_W'(mlo_s7) * RCP_W'(RCP_ODD[RCP_W-1:LIMB]);
			phl_s8  <= RCP_W'(mhi_s7) * RCP_W'(RCP_ODD[LIMB-1:0]);
			phh_s8  <= RCP_W'(mhi_s7) * RCP_W'(RCP_ODD[RCP_W-1:LIMB]);
			capb_s8 <= capb_s7;
			tb_q[0] <= tb_c;
			for (int i = 1; i < POS_DLY; i++) begin
				tb_q[i] <= tb_q[i-1];
			end
		end
	end

	// ---------------------------------------------------------------- velocity tangent divider
	logic              divc_vld;
	logic [DIV_QW-1:0] quob, quoc;
	term_t             ts_q [DIV_LAT];
	term_t             ts_o;

	assign quob = tb_q[POS_DLY-1];

	// Velocity position term: |C| * 1000 / (d * 2^F).
	chse_div u_div_vel (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s6),
		.num     (numc_s6),
		.den     (denc_s6),
		.out_vld (divc_vld),
		.quo     (quoc)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			ts_q[0] <= ts_s6;
			for (int i = 1; i < DIV_LAT; i++) begin
				ts_q[i] <= ts_q[i-1];
			end
		end
	end

	assign ts_o = ts_q[DIV_LAT-1];

	// ---------------------------------------------------------------- output register
	logic signed [TW+1:0] pos_sum, vel_sum;
	logic signed [31:0]   pos_c, vel_c;
	logic                 out_valid_q;
	logic signed [31:0]   position_q, velocity_q;

	assign pos_sum = (TW+2)'(apply_sign(ts_o.na, ts_o.ta)) + (TW+2)'(apply_sign(ts_o.nb, quob));
	assign vel_sum = (TW+2)'(apply_sign(ts_o.nc, quoc)) + (TW+2)'(apply_sign(ts_o.ne, ts_o.te));

	// Zero duration passes the start position; velocity only inside the open segment.
	assign pos_c = ts_o.dz  ? ts_o.p0 : sat32(pos_sum);
	assign vel_c = ts_o.vok ? sat32(vel_sum) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= divc_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			position_q <= pos_c;
			velocity_q <= vel_c;
		end
	end

	assign out_valid    = out_valid_q;
	assign position_out = position_q;
	assign velocity_out = velocity_q;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(position_out) && $stable(velocity_out))
		else $error("stalled result transaction changed");

	a_zero_duration: assert property (@(posedge clk) disable iff (!arst_n)
		en && divc_vld && ts_o.dz |=> velocity_out == '0 && position_out == $past(ts_o.p0))
		else $error("zero-duration transaction gave wrong result");

	a_vel_outside: assert property (@(posedge clk) disable iff (!arst_n)
		en && divc_vld && !ts_o.vok |=> velocity_out == '0)
		else $error("velocity nonzero outside open segment");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty output register");

endmodule

`default_nettype wire

FILE: verif/cubic_hermite_segment_eval_tb.sv
// Testbench for the cubic Hermite segment evaluator: directed and random transactions, scoreboard check.
`timescale 1ns / 1ps

class segment_scoreboard;
	logic signed [31:0] pos_q[$];
	logic signed [31:0] vel_q[$];
	int mismatches;

	// floor(mag*mul/div / 2^24), capped at 2^40
	static function logic [63:0] scale_mag(logic [63:0] mag, logic [31:0] mul, logic [31:0] div);
		logic [127:0] num;
		logic [127:0] quo;
		if (div == 0) return 64'd0;
		num = {64'd0, mag} * {96'd0, mul};
		quo = (num / {96'd0, div}) >> 24;
		if (quo >= (128'd1 << 40)) return 64'd1 << 40;
		return quo[63:0];
	endfunction

	static function logic signed [63:0] scale_term(logic signed [63:0] x, logic [31:0] mul,
			logic [31:0] div);
		logic [63:0] r;
		r = scale_mag(x < 0 ? -x : x, mul, div);
		return x < 0 ? -$signed(r) : $signed(r);
	endfunction

	static function logic signed [31:0] clamp32(logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7fff_ffff;
		if (v < -64'sd2147483648) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function void note_input(logic signed [31:0] p0, logic signed [31:0] v0, logic [31:0] t0,
			logic signed [31:0] p1, logic signed [31:0] v1, logic [31:0] t1, logic [31:0] el);
		logic [31:0] dur;
		logic signed [63:0] one, q, q2, q3, h00, h10, h01, h11, pos, vel, dh00, dh10, dh11;
		logic signed [63:0] sp0, sv0, sp1, sv1;
		dur = t1 - t0;
		one = 64'sd1 << 24;
		sp0 = p0; sv0 = v0; sp1 = p1; sv1 = v1;
		if (dur == 0) begin
			pos_q.push_back(p0);
			vel_q.push_back(32'sd0);
			return;
		end
		if (el >= dur) q = one;
		else q = $signed(({32'd0, el} << 24) / {32'd0, dur});
		q2 = (q * q) >>> 24;
		q3 = (q2 * q) >>> 24;
		h00 = 2 * q3 - 3 * q2 + one;
		h10 = q3 - 2 * q2 + q;
		h01 = -2 * q3 + 3 * q2;
		h11 = q3 - q2;
		pos = scale_term(h00 * sp0 + h01 * sp1, 1, 1)
			+ scale_term(h10 * sv0 + h11 * sv1, dur, 1000);
		vel = 0;
		if (el != 0 && el < dur) begin
			dh00 = 6 * q2 - 6 * q;
			dh10 = 3 * q2 - 4 * q + one;
			dh11 = 3 * q2 - 2 * q;
			vel = clamp32(scale_term(dh00 * (sp0 - sp1), 1000, dur)
				+ scale_term(dh10 * sv0 + dh11 * sv1, 1, 1));
		end
		pos_q.push_back(clamp32(pos));
		vel_q.push_back(vel[31:0]);
	endfunction

	function void check_result(logic signed [31:0] pos, logic signed [31:0] vel);
		logic signed [31:0] ep, ev;
		if (pos_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("unexpected result pos=%0d vel=%0d", pos, vel);
			return;
		end
		ep = pos_q.pop_front();
		ev = vel_q.pop_front();
		if (ep !== pos || ev !== vel) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: pos exp %0d got %0d, vel exp %0d got %0d", ep, pos, ev, vel);
		end
	endfunction
endclass

module cubic_hermite_segment_eval_tb;
	import chse_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [31:0] start_position = '0, start_velocity = '0;
	logic signed [31:0] end_position = '0, end_velocity = '0;
	logic [31:0] start_time_ms = '0, end_time_ms = '0, elapsed_ms = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] position_out, velocity_out;

	segment_scoreboard board;
	bit stimulus_done = 1'b0;

	cubic_hermite_segment_eval DUT (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Gap length: half the time none at all, otherwise mostly short and now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return $urandom_range(0, 3) - 1;
			3: return $signed($urandom_range(0, 20'hfffff)) - 32'sh80000;
			default: return $urandom;
		endcase
	endfunction

	// Drive one transaction and hold it until accepted.
	task automatic send_segment(logic [31:0] p0, logic [31:0] v0, logic [31:0] t0,
			logic [31:0] p1, logic [31:0] v1, logic [31:0] t1, logic [31:0] el);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		start_position <= p0; start_velocity <= v0; start_time_ms <= t0;
		end_position <= p1; end_velocity <= v1; end_time_ms <= t1; elapsed_ms <= el;
		do @(posedge clk); while (in_stall);
		board.note_input(p0, v0, t0, p1, v1, t1, el);
	endtask

	// Random segment: mostly realistic durations, elapsed inside, at or past the end.
	task automatic send_random();
		logic [31:0] t0, dur, el;
		t0 = $urandom;
		case ($urandom_range(0, 9))
			0: dur = 0;
			1: dur = $urandom;
			default: dur = $urandom_range(1, 5000);
		endcase
		case ($urandom_range(0, 9))
			0: el = 0;
			1: el = dur;
			2: el = $urandom;
			3: el = dur + $urandom_range(1, 100);
			default: el = (dur == 0) ? 0 : $urandom_range(0, dur - 1);
		endcase
		send_segment(rand_word(), rand_word(), t0, rand_word(), rand_word(), t0 + dur, el);
	endtask

	initial begin
		board = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: zero duration, elapsed zero, at end, past end, wrapped timestamps, extremes
		send_segment(32'h0001_0000, 32'h0002_0000, 100, 32'h0005_0000, 0, 100, 50);
		send_segment(32'h0001_0000, 32'h0002_0000, 100, 32'h0005_0000, 0, 1100, 0);
		send_segment(32'h0001_0000, 32'h0002_0000, 100, 32'h0005_0000, 0, 1100, 1000);
		send_segment(32'h0001_0000, 32'h0002_0000, 100, 32'h0005_0000, 0, 1100, 32'hffff_ffff);
		send_segment(32'h0001_0000, 32'h0002_0000, 100, 32'h0005_0000, 0, 1100, 500);
		send_segment(32'hfff0_0000, 32'h0010_0000, 32'hffff_ff00, 32'h0010_0000, 0, 32'h100, 256);
		send_segment(32'h0001_0000, 0, 2000, 32'h0003_0000, 0, 1000, 12345);
		send_segment(32'h7fff_ffff, 32'h7fff_ffff, 0, 32'h8000_0000, 32'h8000_0000, 1, 0);
		send_segment(32'h7fff_ffff, 32'h7fff_ffff, 0, 32'h8000_0000, 32'h8000_0000, 3, 1);
		send_segment(32'h8000_0000, 32'h8000_0000, 0, 32'h7fff_ffff, 32'h7fff_ffff, 3, 2);
		send_segment(32'h7fff_ffff, 32'h7fff_ffff, 0, 32'h7fff_ffff, 32'h7fff_ffff,
			32'hffff_ffff, 32'h7fff_ffff);
		send_segment(32'h8000_0000, 32'h8000_0000, 32'hffff_ffff, 32'h7fff_ffff,
			32'h8000_0000, 32'hffff_fffe, 32'hffff_fffe);
		send_segment(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
			32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
		send_segment(32'h1234_5678, 32'hedcb_a987, 7, 32'h8765_4321, 32'h0bad_f00d, 7007, 3500);
		for (int i = 0; i < 500; i++) send_random();
		in_valid <= 1'b0;
		stimulus_done = 1'b1;
	end

	// Output side: random stall pattern with stretches of none.
	initial begin
		int gap;
		forever begin
			@(posedge clk);
			if (stimulus_done && $urandom_range(0, 3) != 0) out_stall <= 1'b0;
			else begin
				gap = pick_gap();
				if (gap > 0) begin
					out_stall <= 1'b1;
					repeat (gap) @(posedge clk);
				end
				out_stall <= 1'b0;
			end
		end
	end

	// Check every accepted result transaction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) board.check_result(position_out, velocity_out);
	end

	initial begin
		wait (stimulus_done);
		while (board.pos_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (board.mismatches == 0 && board.pos_q.size() == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end

	initial begin
		#5ms;
		$display("Regression FAIL");
		$finish;
	end
endmodule
